// File: rtl/track_gap_interpolator_macros.svh
// assertion helpers for the gap interpolator
`ifndef TRACK_GAP_INTERPOLATOR_MACROS_SVH
`define TRACK_GAP_INTERPOLATOR_MACROS_SVH

`define TGI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define TGI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tgi_pkg.sv
package tgi_pkg;

  localparam int unsigned MAX_GAP_DEF       = 64;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DROPPED   = 2'd1;
  localparam logic [1:0] ST_GAP_LONG  = 2'd2;

  typedef struct packed {
    logic        [31:0] key_frame;
    logic        [47:0] key_time;
    logic signed [23:0] key_left;
    logic signed [23:0] key_top;
    logic signed [23:0] key_right;
    logic signed [23:0] key_bottom;
    logic        [15:0] key_confidence;
  } in_item_t;

  typedef struct packed {
    logic        [31:0] out_frame;
    logic        [47:0] out_time;
    logic signed [23:0] out_left;
    logic signed [23:0] out_top;
    logic signed [23:0] out_right;
    logic signed [23:0] out_bottom;
    logic        [15:0] out_confidence;
    logic               is_key;
    logic               last_of_run;
    logic        [1:0]  status;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    in_item_t    key;
    logic [6:0]  gap;      // fill count + 1 when filling, else 0
    logic [1:0]  status;
    logic        is_key;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIV, BK_MUL, BK_ACC, BK_EMIT, BK_KEY
  } bk_state_t;

endpackage

// File: rtl/track_gap_interpolator.sv
// Gap filler for object tracks: takes keyframes in rising frame order and,
// for every frame strictly between the previous keyframe and the new one,
// emits one interpolated state, then the keyframe itself marked last. A gap
// over MAX_GAP sends the keyframe alone with status GAP_LONG, and one not
// after the previous keyframe comes out as a dropped beat. Front end
// classifies keyframes into a two-entry queue; the back end runs a
// bit-serial divide for the fraction, then the products, then emits.
module track_gap_interpolator #(
  parameter int unsigned MAX_GAP       = tgi_pkg::MAX_GAP_DEF,
  parameter int unsigned FRACTION_BITS = tgi_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tgi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tgi_pkg::out_item_t out_data
);

  `include "track_gap_interpolator_macros.svh"

  logic          q_valid, q_ready;
  tgi_pkg::job_t q_job;

  tgi_front #(.MAX_GAP(MAX_GAP)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_ready, .q_job
  );

  tgi_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .out_valid, .out_ready, .out_data
  );

  `TGI_ASSERT_IMPL(a_drop_last, out_valid && out_data.status == tgi_pkg::ST_DROPPED, out_data.last_of_run && !out_data.is_key, "dropped beat must be last and not key")
  `TGI_ASSERT_IMPL(a_fill_ok, out_valid && !out_data.last_of_run, out_data.status == tgi_pkg::ST_OK && !out_data.is_key, "filled beat must be plain")
  `TGI_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled beat changed")

endmodule

// File: rtl/tgi_front.sv
module tgi_front #(
  parameter int unsigned MAX_GAP = tgi_pkg::MAX_GAP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tgi_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output tgi_pkg::job_t     q_job
);

  // two-entry queue between classifier and back end
  tgi_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          have_prev_r;
  logic [31:0]   prev_frame_r;
  logic [32:0]   diff;
  tgi_pkg::job_t job;
  logic          push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_job    = mem_r[rp_r];
  assign diff     = {1'b0, in_data.key_frame} - {1'b0, prev_frame_r};

  always_comb begin
    job.key    = in_data;
    job.gap    = '0;
    job.status = tgi_pkg::ST_OK;
    job.is_key = 1'b1;
    if (have_prev_r) begin
      if (in_data.key_frame <= prev_frame_r) begin
        job.status = tgi_pkg::ST_DROPPED;
        job.is_key = 1'b0;
      end else if (diff > 33'(MAX_GAP)) begin
        job.status = tgi_pkg::ST_GAP_LONG;
      end else begin
        job.gap = diff[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= job;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
      have_prev_r <= 1'b0;
      prev_frame_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
        if (job.status != tgi_pkg::ST_DROPPED) begin
          have_prev_r <= 1'b1;
          prev_frame_r <= in_data.key_frame;
        end
      end
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: rtl/tgi_back.sv
module tgi_back #(
  parameter int unsigned FRACTION_BITS = tgi_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  tgi_pkg::job_t      q_job,
  output logic               out_valid,
  input  logic               out_ready,
  output tgi_pkg::out_item_t out_data
);

  localparam int FB = FRACTION_BITS;
  localparam int XW = FB + 1;
  localparam logic [XW-1:0] ONE = XW'(1) << FB;

  tgi_pkg::bk_state_t state_r, state_nxt;
  tgi_pkg::job_t job_r;
  logic [31:0] pframe_r;
  logic [47:0] ptime_r;
  logic signed [23:0] pbox_r [4];
  logic [15:0] pconf_r;

  logic [6:0]  n_r;
  logic [6:0]  step_r;       // divider step count
  logic [XW+6:0] rem_r;
  logic [XW-1:0] x_r;        // quotient bits
  logic [1:0]  idx_r;        // corner / product index

  logic signed [XW+24:0] acc_r;
  logic [XW+48:0] tacc_r;
  logic [2*XW-1:0] sq_r;
  logic [XW+15:0] cacc_r;
  logic [2*XW-1:0] sx_r;
  logic [47:0] otime_r;
  logic signed [23:0] obox_r [4];
  logic [15:0] oconf_r;

  tgi_pkg::out_item_t ob_r;
  logic ob_v_r, ob_v_nxt;

  logic [XW-1:0] y;
  logic signed [XW+24:0] prod_a;
  logic [XW+6:0] trial;

  assign out_valid = ob_v_r;
  assign out_data  = ob_r;
  assign q_ready   = (state_r == tgi_pkg::BK_IDLE);
  assign y         = ONE - x_r;
  assign trial     = {rem_r[XW+5:0], 1'b0};

  // output beat register loads in emit or key when it is free or draining
  assign ob_v_nxt = (((state_r == tgi_pkg::BK_EMIT) || (state_r == tgi_pkg::BK_KEY))
                     && (!ob_v_r || out_ready)) ? 1'b1 : (ob_v_r && !out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tgi_pkg::BK_IDLE: if (q_valid)
        state_nxt = (q_job.gap > 7'd1) ? tgi_pkg::BK_DIV : tgi_pkg::BK_KEY;
      tgi_pkg::BK_DIV:  if (step_r == 7'(XW - 1)) state_nxt = tgi_pkg::BK_MUL;
      tgi_pkg::BK_MUL:  if (idx_r == 2'd3) state_nxt = tgi_pkg::BK_ACC;
      tgi_pkg::BK_ACC:  state_nxt = tgi_pkg::BK_EMIT;
      tgi_pkg::BK_EMIT: if (!ob_v_r || out_ready)
        state_nxt = (n_r + 7'd1 == job_r.gap) ? tgi_pkg::BK_KEY : tgi_pkg::BK_DIV;
      tgi_pkg::BK_KEY:  if (!ob_v_r || out_ready) state_nxt = tgi_pkg::BK_IDLE;
      default: state_nxt = tgi_pkg::BK_IDLE;
    endcase
  end

  // corner products, one corner per cycle
  assign prod_a = $signed({1'b0, y}) * pbox_r[idx_r];

  logic signed [23:0] kb;
  always_comb begin
    case (idx_r)
      2'd0: kb = job_r.key.key_left;
      2'd1: kb = job_r.key.key_top;
      2'd2: kb = job_r.key.key_right;
      default: kb = job_r.key.key_bottom;
    endcase
  end

  logic signed [XW+25:0] csum;
  assign csum = (XW+26)'(prod_a) + (XW+26)'($signed({1'b0, x_r}) * kb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tgi_pkg::BK_IDLE;
      ob_v_r <= 1'b0;
      pframe_r <= '0;
      ptime_r <= '0;
      pconf_r <= '0;
      for (int i = 0; i < 4; i++) pbox_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ob_v_r <= ob_v_nxt;
      case (state_r)
        tgi_pkg::BK_IDLE: if (q_valid) begin
          job_r <= q_job;
          n_r <= 7'd1;
          step_r <= '0;
          rem_r <= '0;
          x_r <= '0;
        end
        tgi_pkg::BK_DIV: begin
          // restoring divide of n*ONE by gap, one quotient bit a cycle
          if (step_r == '0) begin
            rem_r <= (XW+7)'(n_r);
            x_r <= '0;
          end else if (trial >= (XW+7)'(job_r.gap)) begin
            rem_r <= trial - (XW+7)'(job_r.gap);
            x_r <= {x_r[XW-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            x_r <= {x_r[XW-2:0], 1'b0};
          end
          step_r <= (step_r == 7'(XW - 1)) ? '0 : step_r + 7'd1;
          idx_r <= '0;
        end
        tgi_pkg::BK_MUL: begin
          obox_r[idx_r] <= 24'(csum >>> FB);
          idx_r <= idx_r + 2'd1;
          if (idx_r == 2'd0) begin
            tacc_r <= (XW+49)'(y) * (XW+49)'(ptime_r);
            sq_r <= y * y;
            sx_r <= x_r * x_r;
          end
          if (idx_r == 2'd1) tacc_r <= tacc_r + (XW+49)'(x_r) * (XW+49)'(job_r.key.key_time);
          if (idx_r == 2'd2) cacc_r <= (XW+16)'(sx_r >> FB) * (XW+16)'(pconf_r);
          if (idx_r == 2'd3) cacc_r <= cacc_r
              + (XW+16)'(sq_r >> FB) * (XW+16)'(job_r.key.key_confidence);
        end
        tgi_pkg::BK_ACC: begin
          otime_r <= 48'(tacc_r >> FB);
          oconf_r <= ((cacc_r >> FB) > (XW+16)'(16'hFFFF)) ? 16'hFFFF
                     : 16'(cacc_r >> FB);
        end
        tgi_pkg::BK_EMIT: if (!ob_v_r || out_ready) begin
          ob_r.out_frame <= pframe_r + 32'(n_r);
          ob_r.out_time <= otime_r;
          ob_r.out_left <= obox_r[0];
          ob_r.out_top <= obox_r[1];
          ob_r.out_right <= obox_r[2];
          ob_r.out_bottom <= obox_r[3];
          ob_r.out_confidence <= oconf_r;
          ob_r.is_key <= 1'b0;
          ob_r.last_of_run <= 1'b0;
          ob_r.status <= tgi_pkg::ST_OK;
          n_r <= n_r + 7'd1;
        end
        tgi_pkg::BK_KEY: if (!ob_v_r || out_ready) begin
          ob_r.out_frame <= job_r.key.key_frame;
          ob_r.out_time <= job_r.key.key_time;
          ob_r.out_left <= job_r.key.key_left;
          ob_r.out_top <= job_r.key.key_top;
          ob_r.out_right <= job_r.key.key_right;
          ob_r.out_bottom <= job_r.key.key_bottom;
          ob_r.out_confidence <= job_r.key.key_confidence;
          ob_r.is_key <= job_r.is_key;
          ob_r.last_of_run <= 1'b1;
          ob_r.status <= job_r.status;
          if (job_r.status != tgi_pkg::ST_DROPPED) begin
            pframe_r <= job_r.key.key_frame;
            ptime_r <= job_r.key.key_time;
            pconf_r <= job_r.key.key_confidence;
            pbox_r[0] <= job_r.key.key_left;
            pbox_r[1] <= job_r.key.key_top;
            pbox_r[2] <= job_r.key.key_right;
            pbox_r[3] <= job_r.key.key_bottom;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

class track_scoreboard;
  localparam int unsigned GAP_LIMIT = 64;
  localparam int unsigned FBITS = 16;

  bit have_prev;
  logic [31:0] prev_frame;
  logic [47:0] prev_time;
  logic signed [23:0] prev_box [4];
  logic [15:0] prev_conf;
  tgi_pkg::out_item_t pending_states[$];
  int errors;

  function new();
    have_prev = 0;
    prev_frame = '0;
    prev_time = '0;
    foreach (prev_box[i]) prev_box[i] = '0;
    prev_conf = '0;
    errors = 0;
  endfunction

  // floor(((ONE-x)*a + x*b) / ONE), exact in wide signed math
  function automatic logic signed [23:0] lerp_corner(logic signed [23:0] a,
                                                     logic signed [23:0] b,
                                                     longint x);
    longint s;
    s = ((longint'(1) << FBITS) - x) * longint'(a) + x * longint'(b);
    return 24'(s >>> FBITS);
  endfunction

  function automatic logic [47:0] lerp_time(logic [47:0] t0, logic [47:0] t1,
                                            longint unsigned x);
    logic [127:0] s;
    s = (128'(1) << FBITS) - 128'(x);
    s = s * 128'(t0) + 128'(x) * 128'(t1);
    return 48'(s >> FBITS);
  endfunction

  function automatic logic [15:0] blend_conf(logic [15:0] c0, logic [15:0] c1,
                                             longint unsigned x);
    longint unsigned y, sx, sy, c;
    y = (longint'(1) << FBITS) - x;
    sx = (x * x) >> FBITS;
    sy = (y * y) >> FBITS;
    c = (sx * c0 + sy * c1) >> FBITS;
    return (c > 65535) ? 16'hffff : 16'(c);
  endfunction

  function void note_keyframe(tgi_pkg::in_item_t k);
    tgi_pkg::out_item_t r;
    longint unsigned gap, x;
    logic [1:0] st;
    st = tgi_pkg::ST_OK;
    if (have_prev) begin
      if (k.key_frame <= prev_frame) begin
        r = '{k.key_frame, k.key_time, k.key_left, k.key_top, k.key_right,
              k.key_bottom, k.key_confidence, 1'b0, 1'b1, tgi_pkg::ST_DROPPED};
        pending_states.push_back(r);
        return;
      end
      gap = k.key_frame - prev_frame;
      if (gap > GAP_LIMIT) st = tgi_pkg::ST_GAP_LONG;
      else begin
        for (longint unsigned n = 1; n < gap; n++) begin
          x = (n << FBITS) / gap;
          r.out_frame = prev_frame + 32'(n);
          r.out_time = lerp_time(prev_time, k.key_time, x);
          r.out_left = lerp_corner(prev_box[0], k.key_left, x);
          r.out_top = lerp_corner(prev_box[1], k.key_top, x);
          r.out_right = lerp_corner(prev_box[2], k.key_right, x);
          r.out_bottom = lerp_corner(prev_box[3], k.key_bottom, x);
          r.out_confidence = blend_conf(prev_conf, k.key_confidence, x);
          r.is_key = 0;
          r.last_of_run = 0;
          r.status = tgi_pkg::ST_OK;
          pending_states.push_back(r);
        end
      end
    end
    r = '{k.key_frame, k.key_time, k.key_left, k.key_top, k.key_right,
          k.key_bottom, k.key_confidence, 1'b1, 1'b1, st};
    pending_states.push_back(r);
    have_prev = 1;
    prev_frame = k.key_frame;
    prev_time = k.key_time;
    prev_box[0] = k.key_left;
    prev_box[1] = k.key_top;
    prev_box[2] = k.key_right;
    prev_box[3] = k.key_bottom;
    prev_conf = k.key_confidence;
  endfunction

  function void check_state(tgi_pkg::out_item_t got);
    tgi_pkg::out_item_t exp;
    if (pending_states.size() == 0) begin
      $display("%0t: unexpected beat, actual %h", $time, got);
      errors++;
      return;
    end
    exp = pending_states.pop_front();
    if (got.out_frame !== exp.out_frame)
      report("frame", exp.out_frame, got.out_frame);
    if (got.out_time !== exp.out_time) report("time", exp.out_time, got.out_time);
    if (got.out_left !== exp.out_left) report("left", exp.out_left, got.out_left);
    if (got.out_top !== exp.out_top) report("top", exp.out_top, got.out_top);
    if (got.out_right !== exp.out_right)
      report("right", exp.out_right, got.out_right);
    if (got.out_bottom !== exp.out_bottom)
      report("bottom", exp.out_bottom, got.out_bottom);
    if (got.out_confidence !== exp.out_confidence)
      report("confidence", exp.out_confidence, got.out_confidence);
    if (got.is_key !== exp.is_key) report("is_key", exp.is_key, got.is_key);
    if (got.last_of_run !== exp.last_of_run)
      report("last_of_run", exp.last_of_run, got.last_of_run);
    if (got.status !== exp.status) report("status", exp.status, got.status);
  endfunction

  function void report(string field, logic [63:0] exp, logic [63:0] got);
    $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp, got);
    errors++;
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  tgi_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  tgi_pkg::out_item_t out_data;

  track_scoreboard track_sb = new();
  bit sending_done = 0;
  logic [31:0] next_frame;

  always #5 clk = ~clk;

  track_gap_interpolator dut (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [23:0] rand_corner();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_keyframe(tgi_pkg::in_item_t k);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 0;
      repeat (idle) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= k;
    do @(posedge clk); while (!in_ready);
    track_sb.note_keyframe(k);
  endtask

  task automatic send_at(logic [31:0] frame, logic [15:0] conf);
    tgi_pkg::in_item_t k;
    k.key_frame = frame;
    k.key_time = 48'({$urandom, $urandom});
    k.key_left = rand_corner();
    k.key_top = rand_corner();
    k.key_right = rand_corner();
    k.key_bottom = rand_corner();
    k.key_confidence = conf;
    send_keyframe(k);
  endtask

  task automatic send_random_key();
    int r;
    logic [31:0] f;
    r = $urandom_range(0, 99);
    if (r < 70) f = next_frame + $urandom_range(1, 8);
    else if (r < 80) f = next_frame + $urandom_range(9, 64);
    else if (r < 88) f = next_frame + $urandom_range(65, 5000);
    else if (r < 96) f = next_frame - $urandom_range(0, 20);
    else f = $urandom;
    send_at(f, $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom));
    if (r < 88 || r >= 96) next_frame = track_sb.prev_frame;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) track_sb.check_state(out_data);
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
    end
  end

  initial begin
    tgi_pkg::in_item_t k;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // first keyframe with extremes, then adjacent, max gap, too long, out of order
    k = '{32'd100, 48'h0, 24'h800000, 24'h7fffff, 24'h800000, 24'h7fffff, 16'h0};
    send_keyframe(k);
    k = '{32'd101, 48'hffffffffffff, 24'h7fffff, 24'h800000, 24'h7fffff,
          24'h800000, 16'hffff};
    send_keyframe(k);
    k = '{32'd165, 48'h0, 24'h800000, 24'h7fffff, 24'h0, 24'h1, 16'h0};
    send_keyframe(k);
    send_at(32'd166 + 64, 16'hffff);
    send_at(32'd100, 16'h1234);
    send_at(32'd230, 16'h8000);
    send_at(32'd232, 16'hffff);
    send_at(32'd235, 16'h0);
    send_at(32'hfffffff0, 16'h4321);
    send_at(32'hffffffff, 16'hffff);
    send_at(32'h0, 16'h0);
    send_at(32'hffffffff, 16'h0);
    next_frame = 32'd1000;
    send_at(next_frame, 16'h7777);
    in_valid <= 0;
    // drain fully once before random traffic
    wait (track_sb.pending_states.size() == 0);
    repeat (450) send_random_key();
    in_valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done && track_sb.pending_states.size() == 0);
    repeat (200) @(posedge clk);
    if (track_sb.errors == 0 && track_sb.pending_states.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #100ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// File: track_gap_interpolator.f
+incdir+rtl
rtl/tgi_pkg.sv
rtl/tgi_front.sv
rtl/tgi_back.sv
rtl/track_gap_interpolator.sv
tb/tb.sv
